FILE: sv/feg_pkg.sv
// Shared types and constants for the fade envelope generator.
// Used by every module of the block but feg_div; depends on nothing else.
`timescale 1ns / 1ps

package feg_pkg;

  // Field widths of the stream items and the register port.
  localparam int KIND_W     = 2;
  localparam int TICK_W     = 24;
  localparam int FADE_W     = 24;
  localparam int CFG_W      = 24;
  localparam int PHASE_W    = 3;
  localparam int LEVEL_W    = 13;
  localparam int TIME_W     = 24;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  localparam int OP_W       = 4;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PLAY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;

  // Envelope phases.
  localparam logic [PHASE_W-1:0] PH_STOPPED  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_FADEIN   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ACTIVE   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_FADEOUT  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_FINISHED = 3'd4;

  // Register indexes (byte address is four times the index).
  localparam logic [REG_IDX_W-1:0] REG_FADE_IN  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HOLD     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FADE_OUT = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LOOP     = 2'd3;

  // Datapath operations issued by the controller.
  localparam logic [OP_W-1:0] OP_NONE       = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD       = 4'd1;
  localparam logic [OP_W-1:0] OP_TICK_STOP  = 4'd2;
  localparam logic [OP_W-1:0] OP_TICK_LIN   = 4'd3;
  localparam logic [OP_W-1:0] OP_MOD_START  = 4'd4;
  localparam logic [OP_W-1:0] OP_MOD_APPLY  = 4'd5;
  localparam logic [OP_W-1:0] OP_PLACE      = 4'd6;
  localparam logic [OP_W-1:0] OP_PLAY       = 4'd7;
  localparam logic [OP_W-1:0] OP_STOP_ZERO  = 4'd8;
  localparam logic [OP_W-1:0] OP_LVL_START  = 4'd9;
  localparam logic [OP_W-1:0] OP_STOP_APPLY = 4'd10;
  localparam logic [OP_W-1:0] OP_OUT        = 4'd11;

  typedef struct packed {
    logic [CFG_W-1:0] fade_in;
    logic [CFG_W-1:0] hold;
    logic [CFG_W-1:0] fade_out;
    logic             loop_en;
  } feg_cfg_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } feg_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              idle_ph;
    logic              stop_act;
    logic              need_mod;
    logic              fade_zero;
    logic              div_busy;
    logic              out_free;
  } feg_stat_t;

endpackage

FILE: sv/feg_div.sv
// Restoring divider, one quotient bit per cycle, for the envelope datapath.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module feg_div #(
  parameter int DIVIDEND_W = 37,
  parameter int DIVISOR_W  = 26
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign shifted = {rem, quo[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = ~diff[DIVISOR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIVIDEND_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

FILE: sv/feg_dp.sv
// Envelope datapath: timeline state, level setup, divider and result register.
// Depends on feg_pkg and feg_div.
`timescale 1ns / 1ps

module feg_dp #(
  parameter int TIME_BITS       = 24,
  parameter int LEVEL_FRAC_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  feg_pkg::feg_cfg_t                  cfg,
  input  logic [feg_pkg::KIND_W-1:0]         in_kind,
  input  logic [feg_pkg::TICK_W-1:0]         in_tick,
  input  logic [feg_pkg::FADE_W-1:0]         in_fade,
  input  feg_pkg::feg_cmd_t                  cmd,
  output feg_pkg::feg_stat_t                 stat,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [feg_pkg::PHASE_W-1:0]        out_phase,
  output logic [feg_pkg::LEVEL_W-1:0]        out_level,
  output logic [feg_pkg::TIME_W-1:0]         out_time
);

  localparam int T        = TIME_BITS;
  localparam int L        = LEVEL_FRAC_BITS;
  localparam int CW       = (T > feg_pkg::TICK_W) ? T : feg_pkg::TICK_W;
  localparam int SUM_W    = CW + 1;
  localparam int CYC_W    = T + 2;
  localparam int LVL_DV_W = T + L + 1;
  localparam int DIV_W    = (LVL_DV_W > SUM_W) ? LVL_DV_W : SUM_W;
  localparam int LV_W     = L + 1;

  localparam logic [DIV_W-1:0] TMAX_X = {{(DIV_W - T){1'b0}}, {T{1'b1}}};
  localparam logic [LV_W-1:0]  ONE    = {1'b1, {L{1'b0}}};

  function automatic logic [T-1:0] sat_t(input logic [DIV_W-1:0] v);
    sat_t = (v > TMAX_X) ? TMAX_X[T-1:0] : v[T-1:0];
  endfunction

  // Architectural state.
  logic [feg_pkg::PHASE_W-1:0] phase;
  logic [T-1:0]                elapsed;
  logic [T-1:0]                stop_el;
  logic [T-1:0]                stop_len;
  logic [LV_W-1:0]             stop_start;

  // Item being worked on and level bookkeeping.
  logic [feg_pkg::KIND_W-1:0]  kind;
  logic [feg_pkg::TICK_W-1:0]  dt;
  logic [feg_pkg::FADE_W-1:0]  fade;
  logic [LV_W-1:0]             lvl_direct;
  logic                        lvl_from_div;

  logic [T-1:0]                fi, ho, fo;
  logic [T:0]                  fi_ho;
  logic [CYC_W-1:0]            cycle;
  logic [SUM_W-1:0]            sum, sum_s;
  logic                        idle_ph, stop_act;
  logic [feg_pkg::PHASE_W-1:0] place_ph;
  logic [T-1:0]                mult_diff;
  logic [LVL_DV_W-1:0]         prod;
  logic [T:0]                  d_full;
  logic [T-1:0]                d, fo_rem;
  logic                        lvl_go;
  logic [LV_W-1:0]             lvl_imm, lvl_val;
  logic [DIV_W-1:0]            lvl_a, div_a, div_q;
  logic [CYC_W-1:0]            lvl_b, div_b, div_r;
  logic                        div_start, div_busy;

  assign fi       = sat_t(DIV_W'(cfg.fade_in));
  assign ho       = sat_t(DIV_W'(cfg.hold));
  assign fo       = sat_t(DIV_W'(cfg.fade_out));
  assign fi_ho    = {1'b0, fi} + {1'b0, ho};
  assign cycle    = CYC_W'(fi) + CYC_W'(ho) + CYC_W'(fo);
  assign sum      = SUM_W'(elapsed) + SUM_W'(dt);
  assign sum_s    = SUM_W'(stop_el) + SUM_W'(dt);
  assign idle_ph  = (phase == feg_pkg::PH_STOPPED) || (phase == feg_pkg::PH_FINISHED);
  assign stop_act = |stop_len;

  assign stat.kind      = kind;
  assign stat.idle_ph   = idle_ph;
  assign stat.stop_act  = stop_act;
  assign stat.need_mod  = cfg.loop_en && (|cycle);
  assign stat.fade_zero = ~|fade;
  assign stat.div_busy  = div_busy;
  assign stat.out_free  = ~out_valid | out_ready;

  // Phase for the current elapsed time along the cycle.
  always_comb begin
    priority if ((|fi) && (elapsed < fi)) begin
      place_ph = feg_pkg::PH_FADEIN;
    end else if ({1'b0, elapsed} < fi_ho) begin
      place_ph = feg_pkg::PH_ACTIVE;
    end else if (|fo) begin
      place_ph = feg_pkg::PH_FADEOUT;
    end else begin
      place_ph = cfg.loop_en ? feg_pkg::PH_ACTIVE : feg_pkg::PH_FINISHED;
    end
  end

  assign mult_diff = stop_len - stop_el;
  assign prod      = LVL_DV_W'(stop_start) * LVL_DV_W'(mult_diff);
  assign d_full    = {1'b0, elapsed} - fi_ho;
  assign d         = d_full[T-1:0];
  assign fo_rem    = fo - d;

  // Level setup: either a value known at once or a division to run.
  always_comb begin
    lvl_go  = 1'b0;
    lvl_imm = '0;
    lvl_a   = '0;
    lvl_b   = '0;
    priority if (idle_ph) begin
      lvl_imm = '0;
    end else if (stop_act) begin
      if (stop_el < stop_len) begin
        lvl_go = 1'b1;
        lvl_a  = DIV_W'(prod);
        lvl_b  = CYC_W'(stop_len);
      end
    end else if ((|fi) && (elapsed < fi)) begin
      lvl_go = 1'b1;
      lvl_a  = DIV_W'({elapsed, {L{1'b0}}});
      lvl_b  = CYC_W'(fi);
    end else if ((|fo) && ({1'b0, elapsed} >= fi_ho)) begin
      if (d < fo) begin
        lvl_go = 1'b1;
        lvl_a  = DIV_W'({fo_rem, {L{1'b0}}});
        lvl_b  = CYC_W'(fo);
      end
    end else begin
      lvl_imm = ONE;
    end
  end

  assign div_start = ((cmd.op == feg_pkg::OP_LVL_START) && lvl_go) ||
                     (cmd.op == feg_pkg::OP_MOD_START);
  assign div_a     = (cmd.op == feg_pkg::OP_MOD_START) ? DIV_W'(sum) : lvl_a;
  assign div_b     = (cmd.op == feg_pkg::OP_MOD_START) ? cycle : lvl_b;
  assign lvl_val   = lvl_from_div ? div_q[LV_W-1:0] : lvl_direct;

  feg_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (CYC_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= feg_pkg::PH_STOPPED;
      elapsed    <= '0;
      stop_el    <= '0;
      stop_len   <= '0;
      stop_start <= '0;
      out_valid  <= 1'b0;
    end else begin
      // A new result may replace one that leaves in the same cycle.
      if (cmd.op == feg_pkg::OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        feg_pkg::OP_TICK_STOP: begin
          elapsed <= sat_t(DIV_W'(sum));
          stop_el <= sat_t(DIV_W'(sum_s));
          if (sum_s >= SUM_W'(stop_len)) begin
            phase <= feg_pkg::PH_FINISHED;
          end
        end
        feg_pkg::OP_TICK_LIN: begin
          if (DIV_W'(sum) >= DIV_W'(cycle)) begin
            elapsed <= sat_t(DIV_W'(cycle));
            phase   <= feg_pkg::PH_FINISHED;
          end else begin
            elapsed <= sat_t(DIV_W'(sum));
          end
        end
        feg_pkg::OP_MOD_APPLY: begin
          elapsed <= sat_t(DIV_W'(div_r));
        end
        feg_pkg::OP_PLACE: begin
          if (phase != feg_pkg::PH_FINISHED) begin
            phase <= place_ph;
          end
        end
        feg_pkg::OP_PLAY: begin
          // Phase is parked at stopped so that the following placement runs.
          elapsed    <= '0;
          stop_el    <= '0;
          stop_len   <= '0;
          stop_start <= '0;
          phase      <= feg_pkg::PH_STOPPED;
        end
        feg_pkg::OP_STOP_ZERO: begin
          phase <= feg_pkg::PH_FINISHED;
        end
        feg_pkg::OP_STOP_APPLY: begin
          stop_start <= lvl_val;
          stop_el    <= '0;
          stop_len   <= sat_t(DIV_W'(fade));
          phase      <= feg_pkg::PH_FADEOUT;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == feg_pkg::OP_LOAD) begin
      kind <= in_kind;
      dt   <= in_tick;
      fade <= in_fade;
    end
    if (cmd.op == feg_pkg::OP_LVL_START) begin
      lvl_direct   <= lvl_imm;
      lvl_from_div <= lvl_go;
    end
    if (cmd.op == feg_pkg::OP_OUT) begin
      out_phase <= phase;
      out_level <= feg_pkg::LEVEL_W'(lvl_val);
      out_time  <= feg_pkg::TIME_W'(elapsed);
    end
  end

endmodule

FILE: sv/feg_ctrl.sv
// Envelope controller: sequences each item through update, divide and output.
// Depends on feg_pkg for operation codes and the command and status types.
`timescale 1ns / 1ps

module feg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  feg_pkg::feg_stat_t stat,
  output feg_pkg::feg_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_EXEC      = 3'd1;
  localparam logic [2:0] S_MOD_WAIT  = 3'd2;
  localparam logic [2:0] S_PLACE     = 3'd3;
  localparam logic [2:0] S_SLVL_WAIT = 3'd4;
  localparam logic [2:0] S_LVL       = 3'd5;
  localparam logic [2:0] S_LVL_WAIT  = 3'd6;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = feg_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = feg_pkg::OP_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if ((stat.kind == feg_pkg::KIND_TICK) && !stat.idle_ph) begin
          priority if (stat.stop_act) begin
            cmd.op     = feg_pkg::OP_TICK_STOP;
            state_next = S_LVL;
          end else if (stat.need_mod) begin
            cmd.op     = feg_pkg::OP_MOD_START;
            state_next = S_MOD_WAIT;
          end else begin
            cmd.op     = feg_pkg::OP_TICK_LIN;
            state_next = S_PLACE;
          end
        end else if (stat.kind == feg_pkg::KIND_PLAY) begin
          cmd.op     = feg_pkg::OP_PLAY;
          state_next = S_PLACE;
        end else if ((stat.kind == feg_pkg::KIND_STOP) && !stat.idle_ph) begin
          // A stop with a ramp first needs the level held right now.
          if (stat.fade_zero) begin
            cmd.op     = feg_pkg::OP_STOP_ZERO;
            state_next = S_LVL;
          end else begin
            cmd.op     = feg_pkg::OP_LVL_START;
            state_next = S_SLVL_WAIT;
          end
        end else begin
          state_next = S_LVL;
        end
      end
      S_MOD_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = feg_pkg::OP_MOD_APPLY;
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.op     = feg_pkg::OP_PLACE;
        state_next = S_LVL;
      end
      S_SLVL_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op     = feg_pkg::OP_STOP_APPLY;
          state_next = S_LVL;
        end
      end
      S_LVL: begin
        cmd.op     = feg_pkg::OP_LVL_START;
        state_next = S_LVL_WAIT;
      end
      S_LVL_WAIT: begin
        if (!stat.div_busy && stat.out_free) begin
          cmd.op     = feg_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/fade_envelope_generator_core.sv
// Top level of the fade envelope generator: register port, controller, datapath.
// Depends on feg_pkg, feg_ctrl and feg_dp.
`timescale 1ns / 1ps

// Fade-in / hold / fade-out intensity envelope. Each item on the input stream
// (tick, play or stop) produces exactly one result with the phase, the level in
// fixed point (1 << LEVEL_FRAC_BITS is full) and the elapsed ticks. Items are
// handled one at a time; the result sits in an output register, so the next
// item is taken while it waits. Timing is set by the shared restoring divider,
// which yields one quotient bit per cycle over DIV_W bits, where
// DIV_W = max(TIME_BITS + LEVEL_FRAC_BITS + 1, max(TIME_BITS, 24) + 1), 37 at the
// defaults. An item may need no division, or only the level division; play and
// plain ticks also place the phase again. A stop with a ramp runs two level
// divisions, and a looping tick runs the modulo division and then the level
// division. Registers must be written through the APB port only while no item
// is in flight; the block itself does not enforce this.

module fade_envelope_generator_core #(
  parameter int TIME_BITS       = 24,
  parameter int LEVEL_FRAC_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [feg_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [feg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [feg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tick_count [23:0], stop_fade_ticks [47:24]
  input  logic [feg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind [1:0]
  input  logic [feg_pkg::KIND_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // phase [2:0], level [15:3], time_now [39:16]
  output logic [feg_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  feg_pkg::feg_cfg_t             cfg;
  feg_pkg::feg_cmd_t             cmd;
  feg_pkg::feg_stat_t            stat;
  logic [feg_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;
  logic [feg_pkg::PHASE_W-1:0]   out_phase;
  logic [feg_pkg::LEVEL_W-1:0]   out_level;
  logic [feg_pkg::TIME_W-1:0]    out_time;

  assign pready  = 1'b1;
  assign reg_idx = paddr[feg_pkg::APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        feg_pkg::REG_FADE_IN:  cfg.fade_in  <= pwdata[feg_pkg::CFG_W-1:0];
        feg_pkg::REG_HOLD:     cfg.hold     <= pwdata[feg_pkg::CFG_W-1:0];
        feg_pkg::REG_FADE_OUT: cfg.fade_out <= pwdata[feg_pkg::CFG_W-1:0];
        feg_pkg::REG_LOOP:     cfg.loop_en  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      feg_pkg::REG_FADE_IN:  prdata = feg_pkg::APB_DATA_W'(cfg.fade_in);
      feg_pkg::REG_HOLD:     prdata = feg_pkg::APB_DATA_W'(cfg.hold);
      feg_pkg::REG_FADE_OUT: prdata = feg_pkg::APB_DATA_W'(cfg.fade_out);
      feg_pkg::REG_LOOP:     prdata = feg_pkg::APB_DATA_W'(cfg.loop_en);
      default:               prdata = '0;
    endcase
  end

  feg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  feg_dp #(
    .TIME_BITS       (TIME_BITS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_kind   (s_axis_tuser),
    .in_tick   (s_axis_tdata[feg_pkg::TICK_W-1:0]),
    .in_fade   (s_axis_tdata[feg_pkg::TICK_W +: feg_pkg::FADE_W]),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_phase (out_phase),
    .out_level (out_level),
    .out_time  (out_time)
  );

  assign m_axis_tdata = {out_time, out_level, out_phase};

endmodule

FILE: sv/feg_checker.sv
// Port-level checks for the fade envelope generator, bound to its top level.
// Depends on feg_pkg for the phase codes and field widths.
`timescale 1ns / 1ps

module feg_checker #(
  parameter int LEVEL_FRAC_BITS = 12
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [feg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam logic [16:0] ONE_L = 17'(1) << LEVEL_FRAC_BITS;

  logic [feg_pkg::PHASE_W-1:0] ph;
  logic [feg_pkg::LEVEL_W-1:0] lvl;

  assign ph  = m_axis_tdata[feg_pkg::PHASE_W-1:0];
  assign lvl = m_axis_tdata[feg_pkg::PHASE_W +: feg_pkg::LEVEL_W];

  // No result is left over from before a reset.
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // Items are worked one at a time, so an input transfer closes the input side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again right after a transfer");

  // The level never goes above full scale.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (17'(lvl) <= ONE_L))
    else $error("level above full scale");

  // Stopped and finished envelopes are dark.
  a_idle_dark: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && ((ph == feg_pkg::PH_STOPPED) || (ph == feg_pkg::PH_FINISHED)))
      |-> (lvl == '0))
    else $error("nonzero level in an idle phase");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind fade_envelope_generator_core feg_checker #(
  .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
) u_feg_checker (.*);

FILE: sim/fade_envelope_generator_core_test.sv
// Self-checking testbench for fade_envelope_generator_core. A directed table runs first, then
// random bursts of tick, play, stop and spare items. An in-bench predictor checks each result.
// Depends on feg_pkg and the core RTL only.
`timescale 1ns / 1ps

module fade_envelope_generator_core_test;
  import feg_pkg::*;

  localparam int TIME_BITS_TB       = 24;
  localparam int LEVEL_FRAC_BITS_TB = 12;
  localparam bit [63:0] TIME_MAX    = (64'd1 << TIME_BITS_TB) - 64'd1;
  localparam bit [63:0] LEVEL_ONE   = 64'd1 << LEVEL_FRAC_BITS_TB;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int RANDOM_PHASES   = 15;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int LONG_HOLD       = 500;
  localparam int DRAIN_CYCLES    = 100;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  time_now;
  } env_result_t;

  // One directed step: either a register write (sel is the register index,
  // arg_a the value) or an item (sel is the kind). has_result marks rows whose
  // result is typed in rather than taken from the predictor.
  typedef struct packed {
    bit                 is_cfg;
    logic [1:0]         sel;
    logic [TICK_W-1:0]  arg_a;
    logic [FADE_W-1:0]  arg_b;
    bit                 has_result;
    env_result_t        res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Envelope predictor state, matching the core right after reset.
  bit [CFG_W-1:0]     cfg_fade_in  = '0;
  bit [CFG_W-1:0]     cfg_hold     = '0;
  bit [CFG_W-1:0]     cfg_fade_out = '0;
  bit                 cfg_loop     = 1'b0;
  logic [PHASE_W-1:0] env_phase    = PH_STOPPED;
  bit [63:0]          env_elapsed      = '0;
  bit [63:0]          env_stop_elapsed = '0;
  bit [63:0]          env_stop_len     = '0;
  bit [63:0]          env_stop_level   = '0;

  env_result_t expected_results [$];
  int          mismatches = 0;

  stim_row_t directed_rows [0:37] = '{
    '{1'b0, KIND_TICK,  24'd0,        24'd0,        1'b1, '{PH_STOPPED,  13'd0,    24'd0}},
    '{1'b0, KIND_STOP,  24'd0,        24'd5,        1'b1, '{PH_STOPPED,  13'd0,    24'd0}},
    '{1'b0, KIND_SPARE, 24'hFFFFFF,   24'hFFFFFF,   1'b1, '{PH_STOPPED,  13'd0,    24'd0}},
    '{1'b0, KIND_PLAY,  24'd0,        24'd0,        1'b1, '{PH_FINISHED, 13'd0,    24'd0}},
    '{1'b0, KIND_TICK,  24'hFFFFFF,   24'd0,        1'b1, '{PH_FINISHED, 13'd0,    24'd0}},
    '{1'b1, REG_LOOP,   24'd1,        24'd0,        1'b0, '0},
    '{1'b0, KIND_PLAY,  24'd0,        24'd0,        1'b1, '{PH_ACTIVE,   13'd4096, 24'd0}},
    '{1'b0, KIND_TICK,  24'd7,        24'd0,        1'b1, '{PH_FINISHED, 13'd0,    24'd0}},
    '{1'b1, REG_FADE_IN,  24'd100,    24'd0,        1'b0, '0},
    '{1'b1, REG_HOLD,     24'd50,     24'd0,        1'b0, '0},
    '{1'b1, REG_FADE_OUT, 24'd200,    24'd0,        1'b0, '0},
    '{1'b1, REG_LOOP,     24'd0,      24'd0,        1'b0, '0},
    '{1'b0, KIND_PLAY,  24'd0,        24'd0,        1'b1, '{PH_FADEIN,   13'd0,    24'd0}},
    '{1'b0, KIND_TICK,  24'd50,       24'd0,        1'b1, '{PH_FADEIN,   13'd2048, 24'd50}},
    '{1'b0, KIND_TICK,  24'd75,       24'd0,        1'b1, '{PH_ACTIVE,   13'd4096, 24'd125}},
    '{1'b0, KIND_TICK,  24'd100,      24'd0,        1'b1, '{PH_FADEOUT,  13'd2560, 24'd225}},
    '{1'b0, KIND_STOP,  24'd0,        24'd0,        1'b1, '{PH_FINISHED, 13'd0,    24'd225}},
    '{1'b0, KIND_PLAY,  24'd0,        24'd0,        1'b1, '{PH_FADEIN,   13'd0,    24'd0}},
    '{1'b0, KIND_TICK,  24'd40,       24'd0,        1'b0, '0},
    '{1'b0, KIND_STOP,  24'd0,        24'd10,       1'b0, '0},
    '{1'b0, KIND_TICK,  24'd3,        24'd0,        1'b0, '0},
    '{1'b0, KIND_STOP,  24'd0,        24'hFFFFFF,   1'b0, '0},
    '{1'b0, KIND_TICK,  24'hFFFFFF,   24'd0,        1'b1, '{PH_FINISHED, 13'd0, 24'hFFFFFF}},
    '{1'b1, REG_FADE_IN,  24'hFFFFFF, 24'd0,        1'b0, '0},
    '{1'b1, REG_HOLD,     24'hFFFFFF, 24'd0,        1'b0, '0},
    '{1'b1, REG_FADE_OUT, 24'hFFFFFF, 24'd0,        1'b0, '0},
    '{1'b1, REG_LOOP,     24'd1,      24'd0,        1'b0, '0},
    '{1'b0, KIND_PLAY,  24'd0,        24'd0,        1'b1, '{PH_FADEIN,   13'd0,    24'd0}},
    '{1'b0, KIND_TICK,  24'hFFFFFF,   24'd0,        1'b1, '{PH_ACTIVE, 13'd4096, 24'hFFFFFF}},
    '{1'b0, KIND_TICK,  24'hFFFFFF,   24'd0,        1'b0, '0},
    '{1'b1, REG_LOOP,     24'd0,      24'd0,        1'b0, '0},
    '{1'b1, REG_FADE_IN,  24'd0,      24'd0,        1'b0, '0},
    '{1'b1, REG_HOLD,     24'd0,      24'd0,        1'b0, '0},
    '{1'b1, REG_FADE_OUT, 24'd8,      24'd0,        1'b0, '0},
    '{1'b0, KIND_PLAY,  24'd0,        24'd0,        1'b1, '{PH_FADEOUT,  13'd4096, 24'd0}},
    '{1'b0, KIND_TICK,  24'd3,        24'd0,        1'b0, '0},
    '{1'b0, KIND_TICK,  24'd5,        24'd0,        1'b1, '{PH_FINISHED, 13'd0,    24'd8}},
    '{1'b0, KIND_STOP,  24'd0,        24'd1,        1'b1, '{PH_FINISHED, 13'd0,    24'd8}}
  };

  fade_envelope_generator_core #(
    .TIME_BITS      (TIME_BITS_TB),
    .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS_TB)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic bit [63:0] clamp_time(bit [63:0] v);
    return (v > TIME_MAX) ? TIME_MAX : v;
  endfunction

  function automatic bit env_idle();
    return env_phase == PH_STOPPED || env_phase == PH_FINISHED;
  endfunction

  function automatic void env_place();
    bit [63:0] fi, ho, fo;
    fi = cfg_fade_in;
    ho = cfg_hold;
    fo = cfg_fade_out;
    if (fi != 0 && env_elapsed < fi) env_phase = PH_FADEIN;
    else if (env_elapsed < fi + ho) env_phase = PH_ACTIVE;
    else if (fo != 0) env_phase = PH_FADEOUT;
    else env_phase = cfg_loop ? PH_ACTIVE : PH_FINISHED;
  endfunction

  function automatic bit [63:0] env_level();
    bit [63:0] fi, ho, fo, ramp_start, d, q;
    fi = cfg_fade_in;
    ho = cfg_hold;
    fo = cfg_fade_out;
    if (env_idle()) return 0;
    // A stop ramp overrides the timeline while it runs.
    if (env_stop_len != 0) begin
      if (env_stop_elapsed >= env_stop_len) return 0;
      return env_stop_level * (env_stop_len - env_stop_elapsed) / env_stop_len;
    end
    if (fi != 0 && env_elapsed < fi) begin
      q = env_elapsed * LEVEL_ONE / fi;
      return (q > LEVEL_ONE) ? LEVEL_ONE : q;
    end
    ramp_start = fi + ho;
    if (fo != 0 && env_elapsed >= ramp_start) begin
      d = env_elapsed - ramp_start;
      if (d >= fo) return 0;
      return (fo - d) * LEVEL_ONE / fo;
    end
    return LEVEL_ONE;
  endfunction

  function automatic void env_tick(bit [63:0] dt);
    bit [63:0] sum, cyc;
    if (env_idle()) return;
    if (env_stop_len != 0) begin
      sum = env_stop_elapsed + dt;
      env_elapsed = clamp_time(env_elapsed + dt);
      env_stop_elapsed = clamp_time(sum);
      if (sum >= env_stop_len) env_phase = PH_FINISHED;
      return;
    end
    // Compare and wrap on the full sum; only the stored value saturates.
    sum = env_elapsed + dt;
    cyc = 64'(cfg_fade_in) + 64'(cfg_hold) + 64'(cfg_fade_out);
    if (cfg_loop && cyc != 0) begin
      env_elapsed = clamp_time(sum % cyc);
    end else if (sum >= cyc) begin
      env_elapsed = clamp_time(cyc);
      env_phase = PH_FINISHED;
    end else begin
      env_elapsed = clamp_time(sum);
    end
    if (env_phase != PH_FINISHED) env_place();
  endfunction

  function automatic void env_stop(bit [63:0] len);
    if (env_idle()) return;
    if (len == 0) begin
      env_phase = PH_FINISHED;
      return;
    end
    env_stop_level = env_level();
    env_stop_elapsed = 0;
    env_stop_len = clamp_time(len);
    env_phase = PH_FADEOUT;
  endfunction

  function automatic env_result_t env_step(logic [KIND_W-1:0] kind, logic [TICK_W-1:0] dt,
                                           logic [FADE_W-1:0] fade);
    env_result_t res;
    bit [63:0] lvl;
    case (kind)
      KIND_TICK: env_tick(64'(dt));
      KIND_PLAY: begin
        env_elapsed = 0;
        env_stop_elapsed = 0;
        env_stop_len = 0;
        env_stop_level = 0;
        env_place();
      end
      KIND_STOP: env_stop(64'(fade));
      default: ;
    endcase
    lvl = env_level();
    res.phase = env_phase;
    res.level = lvl[LEVEL_W-1:0];
    res.time_now = env_elapsed[TIME_W-1:0];
    return res;
  endfunction

  function automatic logic [CFG_W-1:0] short_length();
    return ($urandom_range(0, 4) == 0) ? '0 : CFG_W'($urandom_range(1, 300));
  endfunction

  task automatic pause_input(int n);
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(logic [KIND_W-1:0] kind, logic [TICK_W-1:0] dt,
                           logic [FADE_W-1:0] fade, bit has_result, env_result_t res);
    env_result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {fade, dt};
    do @(posedge clk); while (!s_axis_tready);
    // The predictor always advances, even when the row carries its own result.
    predicted = env_step(kind, dt, fade);
    expected_results.push_back(has_result ? res : predicted);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FADE_IN:  cfg_fade_in  = value;
      REG_HOLD:     cfg_hold     = value;
      REG_FADE_OUT: cfg_fade_out = value;
      REG_LOOP:     cfg_loop     = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [CFG_W-1:0] fi, logic [CFG_W-1:0] ho,
                           logic [CFG_W-1:0] fo, logic lp);
    pause_input(0);
    drain_results();
    write_reg(REG_FADE_IN, fi);
    write_reg(REG_HOLD, ho);
    write_reg(REG_FADE_OUT, fo);
    write_reg(REG_LOOP, CFG_W'(lp));
  endtask

  initial begin
    int burst, r;
    logic [KIND_W-1:0] kind;
    logic [TICK_W-1:0] dt;
    logic [FADE_W-1:0] fade;
    stim_row_t row;
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        pause_input(0);
        drain_results();
        write_reg(row.sel, row.arg_a);
      end else begin
        send_item(row.sel, row.arg_a, row.arg_b, row.has_result, row.res);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        1: configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
        2: configure('0, '0, '0, 1'b1);
        3: configure(24'($urandom), 24'($urandom), 24'($urandom), 1'($urandom));
        default: configure(short_length(), short_length(), short_length(), 1'($urandom));
      endcase
      // Every phase opens with a play so the envelope leaves its idle states.
      send_item(KIND_PLAY, 24'($urandom), 24'($urandom), 1'b0, '0);
      burst = $urandom_range(1, 30);
      for (int k = 1; k < ITEMS_PER_PHASE; k++) begin
        if (burst == 0) begin
          pause_input($urandom_range(1, 15));
          burst = $urandom_range(1, 30);
        end
        r = $urandom_range(0, 99);
        if (r < 8) kind = KIND_PLAY;
        else if (r < 78) kind = KIND_TICK;
        else if (r < 93) kind = KIND_STOP;
        else kind = KIND_SPARE;
        r = $urandom_range(0, 99);
        if (r < 60) dt = 24'($urandom_range(0, 48));
        else if (r < 85) dt = 24'($urandom_range(0, 1000));
        else dt = 24'($urandom);
        r = $urandom_range(0, 99);
        if (r < 20) fade = '0;
        else if (r < 70) fade = 24'($urandom_range(1, 64));
        else fade = 24'($urandom);
        send_item(kind, dt, fade, 1'b0, '0);
        burst--;
      end
    end

    pause_input(0);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin : receiver
    int rx_cycles, hold_at, n;
    bit on;
    rx_cycles = 0;
    hold_at = 6000;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_cycles >= hold_at) begin
        // Long hold-off: the output register fills and the core must stall its input.
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rx_cycles += LONG_HOLD;
        hold_at += 20000;
      end
      on = ($urandom_range(0, 3) != 0);
      n = on ? $urandom_range(1, 40) : $urandom_range(1, 12);
      m_axis_tready <= on;
      repeat (n) @(posedge clk);
      rx_cycles += n;
    end
  end

  always @(posedge clk) begin
    env_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.phase    = m_axis_tdata[2:0];
      got.level    = m_axis_tdata[15:3];
      got.time_now = m_axis_tdata[39:16];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: phase=%0d level=%0d time_now=%0d",
                   got.phase, got.level, got.time_now);
      end else begin
        want = expected_results.pop_front();
        if (got.phase !== want.phase || got.level !== want.level ||
            got.time_now !== want.time_now) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected phase=%0d level=%0d time_now=%0d, got %0d %0d %0d",
                     want.phase, want.level, want.time_now,
                     got.phase, got.level, got.time_now);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
